@@ design/infix_to_postfix_converter_macros.svh @@
// shared assertion macros for the infix to postfix converter
`ifndef INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH

// same-cycle implication
`define IPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipc check failed");

// next-cycle implication
`define IPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipc check failed");

`endif

@@ design/ipc_pkg.sv @@
`default_nettype none

package ipc_pkg;

    // input token kinds
    localparam logic [2:0] KIND_OPERAND = 3'd0;
    localparam logic [2:0] KIND_PLUS    = 3'd1;
    localparam logic [2:0] KIND_MINUS   = 3'd2;
    localparam logic [2:0] KIND_TIMES   = 3'd3;
    localparam logic [2:0] KIND_DIVIDE  = 3'd4;
    localparam logic [2:0] KIND_OPEN    = 3'd5;
    localparam logic [2:0] KIND_CLOSE   = 3'd6;
    localparam logic [2:0] KIND_END     = 3'd7;

    // result kinds beyond the operator codes
    localparam logic [2:0] OUT_OPERAND = 3'd0;
    localparam logic [2:0] OUT_DONE    = 3'd5;
    localparam logic [2:0] OUT_ERROR   = 3'd6;

    // error codes
    localparam logic [2:0] ERR_NONE          = 3'd0;
    localparam logic [2:0] ERR_MISSING_OPND  = 3'd1;
    localparam logic [2:0] ERR_UNMATCHED_CLS = 3'd2;
    localparam logic [2:0] ERR_DOUBLE_OP     = 3'd3;
    localparam logic [2:0] ERR_BAD_ENDING    = 3'd4;
    localparam logic [2:0] ERR_UNMATCHED_OPN = 3'd5;
    localparam logic [2:0] ERR_OVERFLOW      = 3'd6;

    // class of the previous token
    localparam logic [2:0] CLS_NONE     = 3'd0;
    localparam logic [2:0] CLS_OPERAND  = 3'd1;
    localparam logic [2:0] CLS_OPERATOR = 3'd2;
    localparam logic [2:0] CLS_OPEN     = 3'd3;
    localparam logic [2:0] CLS_CLOSE    = 3'd4;

    typedef struct packed {
        logic       load;
        logic       stack_push;
        logic       stack_pop;
        logic       stack_read;
        logic       set_prev;
        logic [2:0] prev;
        logic       set_disc;
        logic       clear;
        logic       res_en;
        logic       res_last;
        logic [2:0] res_kind;
        logic [2:0] res_code;
        logic       res_fin;
    } t_cmd;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] prev;
        logic       disc;
        logic       empty;
        logic       full;
        logic       one;
        logic [2:0] top;
        logic       hold_v;
        logic       out_free;
    } t_sts;

    function automatic logic prec_hi(input logic [2:0] k);
        return (k == KIND_TIMES) || (k == KIND_DIVIDE);
    endfunction

endpackage

`default_nettype wire

@@ design/ipc_datapath.sv @@
`default_nettype none
`include "infix_to_postfix_converter_macros.svh"

module ipc_datapath #(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ipc_pkg::t_cmd                 i_cmd,
    output ipc_pkg::t_sts                      o_sts,
    input  wire logic [2:0]                    i_kind,
    input  wire logic signed [VALUE_WIDTH-1:0] i_operand_value,
    input  wire logic                          i_stall,
    output logic                               o_valid,
    output logic [2:0]                         o_out_kind,
    output logic signed [VALUE_WIDTH-1:0]      o_out_value,
    output logic [2:0]                         o_error_code,
    output logic                               o_last
);
    import ipc_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [2:0]                    r_kind;
    logic signed [VALUE_WIDTH-1:0] r_value;
    logic [CW-1:0]                 r_count, n_count;
    logic [2:0]                    r_prev, n_prev;
    logic                          r_disc, n_disc;
    logic [2:0]                    mem [STACK_DEPTH];
    logic [2:0]                    r_top;
    logic [CW-1:0]                 w_cnt_m1;

    logic                          r_hv, n_hv;
    logic [2:0]                    r_hkind, r_hcode;
    logic signed [VALUE_WIDTH-1:0] r_hvalue;
    logic                          r_ov, n_ov;
    logic [2:0]                    r_okind, r_ocode;
    logic signed [VALUE_WIDTH-1:0] r_ovalue;
    logic                          r_olast;

    logic                          w_out_free;
    logic                          w_load_out;
    logic                          w_from_hold;
    logic signed [VALUE_WIDTH-1:0] w_res_value;

    assign w_cnt_m1    = r_count - CW'(1);
    assign w_out_free  = !r_ov || !i_stall;
    assign w_res_value = (i_cmd.res_kind == OUT_OPERAND) ? r_value : '0;
    // the held result moves out when a newer one replaces it, or at the end of an item
    assign w_from_hold = i_cmd.res_fin || (i_cmd.res_en && !i_cmd.res_last && r_hv);
    assign w_load_out  = w_from_hold || (i_cmd.res_en && i_cmd.res_last);

    always_comb begin
        n_count = r_count;
        n_prev  = r_prev;
        n_disc  = r_disc;
        if (i_cmd.clear) begin
            n_count = '0;
            n_prev  = CLS_NONE;
            n_disc  = 1'b0;
        end else begin
            if (i_cmd.stack_push) begin
                n_count = r_count + CW'(1);
            end else if (i_cmd.stack_pop) begin
                n_count = w_cnt_m1;
            end
            if (i_cmd.set_prev) begin
                n_prev = i_cmd.prev;
            end
            if (i_cmd.set_disc) begin
                n_disc = 1'b1;
            end
        end
        n_hv = r_hv;
        if (i_cmd.res_fin) begin
            n_hv = 1'b0;
        end else if (i_cmd.res_en && !i_cmd.res_last) begin
            n_hv = 1'b1;
        end
        n_ov = w_load_out ? 1'b1 : (r_ov && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_prev  <= CLS_NONE;
            r_disc  <= 1'b0;
            r_hv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_count <= n_count;
            r_prev  <= n_prev;
            r_disc  <= n_disc;
            r_hv    <= n_hv;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.stack_push) begin
            mem[r_count[AW-1:0]] <= r_kind;
        end
        if (i_cmd.stack_read) begin
            r_top <= mem[w_cnt_m1[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_value <= i_operand_value;
        end
        if (i_cmd.res_en && !i_cmd.res_last) begin
            r_hkind  <= i_cmd.res_kind;
            r_hcode  <= i_cmd.res_code;
            r_hvalue <= w_res_value;
        end
        if (w_from_hold) begin
            r_okind  <= r_hkind;
            r_ocode  <= r_hcode;
            r_ovalue <= r_hvalue;
            r_olast  <= i_cmd.res_fin;
        end else if (i_cmd.res_en && i_cmd.res_last) begin
            r_okind  <= i_cmd.res_kind;
            r_ocode  <= i_cmd.res_code;
            r_ovalue <= w_res_value;
            r_olast  <= 1'b1;
        end
    end

    always_comb begin
        o_sts          = '0;
        o_sts.kind     = r_kind;
        o_sts.prev     = r_prev;
        o_sts.disc     = r_disc;
        o_sts.empty    = (r_count == '0);
        o_sts.full     = (r_count == CW'(STACK_DEPTH));
        o_sts.one      = (r_count == CW'(1));
        o_sts.top      = r_top;
        o_sts.hold_v   = r_hv;
        o_sts.out_free = w_out_free;
    end

    assign o_valid      = r_ov;
    assign o_out_kind   = r_okind;
    assign o_out_value  = r_ovalue;
    assign o_error_code = r_ocode;
    assign o_last       = r_olast;

    `IPC_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(STACK_DEPTH))
    `IPC_ASSERT_IMPL(a_fin_has_hold, i_clk, i_rst_n, i_cmd.res_fin, r_hv)
    `IPC_ASSERT_IMPL(a_out_slot_free, i_clk, i_rst_n, w_load_out, w_out_free)
    `IPC_ASSERT_NEXT(a_fin_drains, i_clk, i_rst_n, i_cmd.res_fin, !r_hv && r_ov && r_olast)

endmodule

`default_nettype wire

@@ design/ipc_ctrl.sv @@
`default_nettype none
`include "infix_to_postfix_converter_macros.svh"

module ipc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire ipc_pkg::t_sts i_sts,
    output ipc_pkg::t_cmd      o_cmd
);
    import ipc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD,
        S_CHK,
        S_EMPTY,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    t_state w_after;

    // an item ends through the drain step if a popped result is still held
    assign w_after = i_sts.hold_v ? S_FIN : S_IDLE;
    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.disc) begin
                    o_cmd.clear = (i_sts.kind == KIND_END);
                    n_state     = S_IDLE;
                end else begin
                    case (i_sts.kind)
                        KIND_OPERAND: begin
                            if (i_sts.out_free) begin
                                o_cmd.res_en   = 1'b1;
                                o_cmd.res_last = 1'b1;
                                o_cmd.res_kind = OUT_OPERAND;
                                o_cmd.set_prev = 1'b1;
                                o_cmd.prev     = CLS_OPERAND;
                                n_state        = S_IDLE;
                            end
                        end
                        KIND_OPEN: begin
                            if (i_sts.full) begin
                                if (i_sts.out_free) begin
                                    o_cmd.res_en   = 1'b1;
                                    o_cmd.res_last = 1'b1;
                                    o_cmd.res_kind = OUT_ERROR;
                                    o_cmd.res_code = ERR_OVERFLOW;
                                    o_cmd.set_disc = 1'b1;
                                    n_state        = S_IDLE;
                                end
                            end else begin
                                o_cmd.stack_push = 1'b1;
                                o_cmd.set_prev   = 1'b1;
                                o_cmd.prev       = CLS_OPEN;
                                n_state          = S_IDLE;
                            end
                        end
                        KIND_CLOSE: begin
                            if (i_sts.prev inside {CLS_OPERATOR, CLS_NONE}) begin
                                if (i_sts.out_free) begin
                                    o_cmd.res_en   = 1'b1;
                                    o_cmd.res_last = 1'b1;
                                    o_cmd.res_kind = OUT_ERROR;
                                    o_cmd.res_code = ERR_MISSING_OPND;
                                    o_cmd.set_disc = 1'b1;
                                    n_state        = S_IDLE;
                                end
                            end else if (i_sts.empty) begin
                                n_state = S_EMPTY;
                            end else begin
                                o_cmd.stack_read = 1'b1;
                                n_state          = S_CHK;
                            end
                        end
                        KIND_END: begin
                            if (i_sts.prev inside {CLS_OPERATOR, CLS_OPEN}) begin
                                if (i_sts.out_free) begin
                                    o_cmd.res_en   = 1'b1;
                                    o_cmd.res_last = 1'b1;
                                    o_cmd.res_kind = OUT_ERROR;
                                    o_cmd.res_code = ERR_BAD_ENDING;
                                    o_cmd.clear    = 1'b1;
                                    n_state        = S_IDLE;
                                end
                            end else if (i_sts.empty) begin
                                n_state = S_EMPTY;
                            end else begin
                                o_cmd.stack_read = 1'b1;
                                n_state          = S_CHK;
                            end
                        end
                        default: begin
                            // the four operators
                            if (i_sts.prev == CLS_OPERATOR) begin
                                if (i_sts.out_free) begin
                                    o_cmd.res_en   = 1'b1;
                                    o_cmd.res_last = 1'b1;
                                    o_cmd.res_kind = OUT_ERROR;
                                    o_cmd.res_code = ERR_DOUBLE_OP;
                                    o_cmd.set_disc = 1'b1;
                                    n_state        = S_IDLE;
                                end
                            end else if (i_sts.empty) begin
                                n_state = S_EMPTY;
                            end else begin
                                o_cmd.stack_read = 1'b1;
                                n_state          = S_CHK;
                            end
                        end
                    endcase
                end
            end
            S_RD: begin
                o_cmd.stack_read = 1'b1;
                n_state          = S_CHK;
            end
            S_CHK: begin
                if (i_sts.kind == KIND_CLOSE && i_sts.top == KIND_OPEN) begin
                    o_cmd.stack_pop = 1'b1;
                    o_cmd.set_prev  = 1'b1;
                    o_cmd.prev      = CLS_CLOSE;
                    n_state         = w_after;
                end else if (i_sts.kind == KIND_END && i_sts.top == KIND_OPEN) begin
                    if (i_sts.out_free) begin
                        o_cmd.res_en   = 1'b1;
                        o_cmd.res_last = !i_sts.hold_v;
                        o_cmd.res_kind = OUT_ERROR;
                        o_cmd.res_code = ERR_UNMATCHED_OPN;
                        o_cmd.clear    = 1'b1;
                        n_state        = w_after;
                    end
                end else if (i_sts.kind != KIND_CLOSE && i_sts.kind != KIND_END &&
                             (i_sts.top == KIND_OPEN ||
                              (prec_hi(i_sts.kind) && !prec_hi(i_sts.top)))) begin
                    // operator stops popping and goes on the stack, or reports overflow if the stack is full
                    if (i_sts.full) begin
                        if (i_sts.out_free) begin
                            o_cmd.res_en   = 1'b1;
                            o_cmd.res_last = !i_sts.hold_v;
                            o_cmd.res_kind = OUT_ERROR;
                            o_cmd.res_code = ERR_OVERFLOW;
                            o_cmd.set_disc = 1'b1;
                            n_state        = w_after;
                        end
                    end else begin
                        o_cmd.stack_push = 1'b1;
                        o_cmd.set_prev   = 1'b1;
                        o_cmd.prev       = CLS_OPERATOR;
                        n_state          = w_after;
                    end
                end else if (i_sts.out_free) begin
                    // pop one operator to the result stream
                    o_cmd.res_en    = 1'b1;
                    o_cmd.res_kind  = i_sts.top;
                    o_cmd.stack_pop = 1'b1;
                    n_state         = i_sts.one ? S_EMPTY : S_RD;
                end
            end
            S_EMPTY: begin
                case (i_sts.kind)
                    KIND_CLOSE: begin
                        if (i_sts.out_free) begin
                            o_cmd.res_en   = 1'b1;
                            o_cmd.res_last = !i_sts.hold_v;
                            o_cmd.res_kind = OUT_ERROR;
                            o_cmd.res_code = ERR_UNMATCHED_CLS;
                            o_cmd.set_disc = 1'b1;
                            n_state        = w_after;
                        end
                    end
                    KIND_END: begin
                        if (i_sts.out_free) begin
                            o_cmd.res_en   = 1'b1;
                            o_cmd.res_last = !i_sts.hold_v;
                            o_cmd.res_kind = OUT_DONE;
                            o_cmd.clear    = 1'b1;
                            n_state        = w_after;
                        end
                    end
                    default: begin
                        // an operator onto an empty stack
                        o_cmd.stack_push = 1'b1;
                        o_cmd.set_prev   = 1'b1;
                        o_cmd.prev       = CLS_OPERATOR;
                        n_state          = w_after;
                    end
                endcase
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.res_fin = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `IPC_ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, o_cmd.stack_push, !i_sts.full)
    `IPC_ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, o_cmd.stack_pop, !i_sts.empty)

endmodule

`default_nettype wire

@@ design/infix_to_postfix_converter.sv @@
// one item at a time: an operand, '(' or a rejected token is handled in the execute state
// an operator, ')' or end scans the operator stack, popping one operator per step;
// each step reads the top through the one registered read port of the stack memory
// results leave through an output register; a stalled output holds the scan
// synchronous active-low reset empties the stack, clears the previous class,
// the discard flag and both result registers; stack entries are not cleared
`default_nettype none

module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [2:0]                    i_kind,
    input  wire logic signed [VALUE_WIDTH-1:0] i_operand_value,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [2:0]                         o_out_kind,
    output logic signed [VALUE_WIDTH-1:0]      o_out_value,
    output logic [2:0]                         o_error_code,
    output logic                               o_last
);
    import ipc_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    ipc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    ipc_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_kind          (i_kind),
        .i_operand_value (i_operand_value),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_out_kind      (o_out_kind),
        .o_out_value     (o_out_value),
        .o_error_code    (o_error_code),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ipc_pkg::*;

    localparam int DEPTH       = 16;
    localparam int VW          = 32;
    localparam int TOKEN_GOAL  = 370;
    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [2:0]           kind;
        logic signed [VW-1:0] value;
        logic                 pause;
    } t_token;

    typedef struct packed {
        logic [2:0]           kind;
        logic signed [VW-1:0] value;
        logic [2:0]           code;
        logic                 last;
    } t_postfix;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_SCATTER,
        STALL_RUNS,
        STALL_ALTERNATE
    } t_stall_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [2:0]           i_kind = KIND_END;
    logic signed [VW-1:0] i_operand_value = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [2:0]           o_out_kind;
    logic signed [VW-1:0] o_out_value;
    logic [2:0]           o_error_code;
    logic                 o_last;

    infix_to_postfix_converter #(
        .STACK_DEPTH(DEPTH),
        .VALUE_WIDTH(VW)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_operand_value (i_operand_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_kind      (o_out_kind),
        .o_out_value     (o_out_value),
        .o_error_code    (o_error_code),
        .o_last          (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    t_token      pending[$];
    t_postfix    postfix_q[$];
    int          pause_count = 0;
    int          fail_count = 0;
    int unsigned cycle_count = 0;
    logic        in_taken = 1'b0;

    // shadow of the converter state
    logic [2:0]  held_ops [DEPTH];
    int          held_count = 0;
    logic [2:0]  last_class = CLS_NONE;
    bit          dropping = 1'b0;

    function automatic bit is_mul_div(input logic [2:0] k);
        return (k == KIND_TIMES) || (k == KIND_DIVIDE);
    endfunction

    task automatic emit_postfix(input logic [2:0] kind, input logic signed [VW-1:0] value,
                                input logic [2:0] code);
        t_postfix r;
        r.kind  = kind;
        r.value = value;
        r.code  = code;
        r.last  = 1'b0;
        postfix_q.push_back(r);
    endtask

    task automatic clear_shunt();
        held_count = 0;
        last_class = CLS_NONE;
        dropping   = 1'b0;
    endtask

    task automatic shunt_token(input logic [2:0] kind, input logic signed [VW-1:0] value);
        int       first;
        bit       found;
        t_postfix tail;
        first = postfix_q.size();
        if (dropping) begin
            if (kind == KIND_END) clear_shunt();
        end else begin
            case (kind)
                KIND_OPERAND: begin
                    emit_postfix(OUT_OPERAND, value, ERR_NONE);
                    last_class = CLS_OPERAND;
                end
                KIND_OPEN: begin
                    if (held_count >= DEPTH) begin
                        emit_postfix(OUT_ERROR, '0, ERR_OVERFLOW);
                        dropping = 1'b1;
                    end else begin
                        held_ops[held_count] = KIND_OPEN;
                        held_count++;
                        last_class = CLS_OPEN;
                    end
                end
                KIND_CLOSE: begin
                    if (last_class == CLS_OPERATOR || last_class == CLS_NONE) begin
                        emit_postfix(OUT_ERROR, '0, ERR_MISSING_OPND);
                        dropping = 1'b1;
                    end else begin
                        found = 1'b0;
                        while (held_count > 0 && !found) begin
                            held_count--;
                            if (held_ops[held_count] == KIND_OPEN) found = 1'b1;
                            else emit_postfix(held_ops[held_count], '0, ERR_NONE);
                        end
                        if (!found) begin
                            emit_postfix(OUT_ERROR, '0, ERR_UNMATCHED_CLS);
                            dropping = 1'b1;
                        end else begin
                            last_class = CLS_CLOSE;
                        end
                    end
                end
                KIND_END: begin
                    if (last_class == CLS_OPERATOR || last_class == CLS_OPEN) begin
                        emit_postfix(OUT_ERROR, '0, ERR_BAD_ENDING);
                    end else begin
                        while (held_count > 0 && held_ops[held_count-1] != KIND_OPEN) begin
                            emit_postfix(held_ops[held_count-1], '0, ERR_NONE);
                            held_count--;
                        end
                        if (held_count > 0) emit_postfix(OUT_ERROR, '0, ERR_UNMATCHED_OPN);
                        else emit_postfix(OUT_DONE, '0, ERR_NONE);
                    end
                    clear_shunt();
                end
                default: begin
                    if (last_class == CLS_OPERATOR) begin
                        emit_postfix(OUT_ERROR, '0, ERR_DOUBLE_OP);
                        dropping = 1'b1;
                    end else begin
                        // pop while the top binds at least as tight (left-assoc)
                        while (held_count > 0 && held_ops[held_count-1] != KIND_OPEN &&
                               !(is_mul_div(kind) && !is_mul_div(held_ops[held_count-1])))
                        begin
                            emit_postfix(held_ops[held_count-1], '0, ERR_NONE);
                            held_count--;
                        end
                        if (held_count >= DEPTH) begin
                            emit_postfix(OUT_ERROR, '0, ERR_OVERFLOW);
                            dropping = 1'b1;
                        end else begin
                            held_ops[held_count] = kind;
                            held_count++;
                            last_class = CLS_OPERATOR;
                        end
                    end
                end
            endcase
        end
        if (postfix_q.size() > first) begin
            tail = postfix_q.pop_back();
            tail.last = 1'b1;
            postfix_q.push_back(tail);
        end
    endtask

    // stimulus building

    function automatic logic signed [VW-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return {1'b1, {(VW-1){1'b0}}};
            1: return {1'b0, {(VW-1){1'b1}}};
            2: return $urandom_range(0, 9);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] rand_op();
        return 3'($urandom_range(KIND_PLUS, KIND_DIVIDE));
    endfunction

    task automatic push_tok(input logic [2:0] kind, input logic signed [VW-1:0] value);
        t_token tk;
        tk.kind  = kind;
        tk.value = value;
        tk.pause = 1'b0;
        pending.push_back(tk);
    endtask

    task automatic push_pause();
        t_token tk;
        tk.kind  = KIND_END;
        tk.value = '0;
        tk.pause = 1'b1;
        pending.push_back(tk);
        pause_count++;
    endtask

    // non-operand tokens carry random values too, the block must ignore them
    task automatic push_kind(input logic [2:0] kind);
        push_tok(kind, $urandom);
    endtask

    task automatic gen_expr(input int levels);
        int terms;
        terms = $urandom_range(1, 4);
        for (int t = 0; t < terms; t++) begin
            if (t > 0) push_kind(rand_op());
            if (levels > 0 && $urandom_range(0, 2) == 0) begin
                push_kind(KIND_OPEN);
                gen_expr(levels - 1);
                push_kind(KIND_CLOSE);
            end else begin
                push_tok(KIND_OPERAND, rand_value());
                if ($urandom_range(0, 15) == 0) push_tok(KIND_OPERAND, rand_value());
            end
        end
    endtask

    task automatic gen_deep(input int levels, input int mix_pct, input bit lead_op);
        int closes;
        for (int l = 0; l < levels; l++) begin
            push_kind(KIND_OPEN);
            if ($urandom_range(0, 99) < mix_pct) begin
                push_tok(KIND_OPERAND, rand_value());
                push_kind(rand_op());
            end
        end
        if (lead_op) push_kind(rand_op());
        push_tok(KIND_OPERAND, rand_value());
        closes = $urandom_range(0, levels + 1);
        repeat (closes) push_kind(KIND_CLOSE);
        push_kind(KIND_END);
    endtask

    task automatic gen_broken();
        int     start;
        int     idx;
        t_token tk;
        start = pending.size();
        gen_expr(2);
        idx = $urandom_range(start, pending.size() - 1);
        if ($urandom_range(0, 1) == 0) begin
            tk = pending[idx];
            tk.kind = 3'($urandom_range(KIND_OPERAND, KIND_CLOSE));
            pending[idx] = tk;
        end else if (pending.size() - start > 1) begin
            pending.delete(idx);
        end
        if ($urandom_range(0, 3) == 0) push_kind(rand_op());
        push_kind(KIND_END);
    endtask

    task automatic gen_noise();
        int len;
        len = $urandom_range(1, 12);
        repeat (len) push_kind(3'($urandom_range(KIND_OPERAND, KIND_CLOSE)));
        // sometimes the next sequence continues this one
        if ($urandom_range(0, 3) != 0) push_kind(KIND_END);
    endtask

    task automatic build_directed();
        push_kind(KIND_END);
        push_tok(KIND_OPERAND, {1'b0, {(VW-1){1'b1}}});
        push_kind(KIND_MINUS);
        push_tok(KIND_OPERAND, {1'b1, {(VW-1){1'b0}}});
        push_kind(KIND_TIMES);
        push_tok(KIND_OPERAND, '0);
        push_kind(KIND_DIVIDE);
        push_tok(KIND_OPERAND, '1);
        push_kind(KIND_END);
        // empty parentheses
        push_kind(KIND_OPEN);
        push_kind(KIND_CLOSE);
        push_kind(KIND_END);
        // close at start
        push_kind(KIND_CLOSE);
        push_kind(KIND_END);
        // close with no open, times popped first
        push_tok(KIND_OPERAND, 1);
        push_kind(KIND_TIMES);
        push_tok(KIND_OPERAND, 2);
        push_kind(KIND_CLOSE);
        push_kind(KIND_END);
        // leading operator accepted, then two in a row
        push_kind(KIND_PLUS);
        push_kind(KIND_PLUS);
        push_kind(KIND_END);
        // end right after open
        push_kind(KIND_OPEN);
        push_kind(KIND_END);
        // open left on the stack at end
        push_kind(KIND_OPEN);
        push_tok(KIND_OPERAND, 3);
        push_kind(KIND_PLUS);
        push_tok(KIND_OPERAND, 4);
        push_kind(KIND_END);
    endtask

    task automatic build_random();
        int pick;
        // overflow on open, then on an operator over a full stack of opens
        gen_deep(DEPTH + 1, 0, 1'b0);
        gen_deep(DEPTH, 0, 1'b1);
        while (pending.size() - pause_count < TOKEN_GOAL) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                if ($urandom_range(0, 9) == 0) push_kind(rand_op());
                gen_expr($urandom_range(0, 3));
                push_kind(KIND_END);
            end else if (pick < 70) begin
                gen_deep($urandom_range(3, 12), 50, $urandom_range(0, 3) == 0);
            end else if (pick < 85) begin
                gen_broken();
            end else begin
                gen_noise();
            end
            if ($urandom_range(0, 7) == 0) push_pause();
        end
        push_kind(KIND_END);
    endtask

    // sender: bursts with gaps, pauses until drained on a marker item
    int     burst_left = 1;
    int     gap_left = 0;
    t_token next_tok;

    task automatic new_burst();
        if ($urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(30, 60);
            gap_left   = 0;
        end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = $urandom_range(0, 8);
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (pending.size() != 0 && pending[0].pause) begin
                i_valid <= 1'b0;
                if (postfix_q.size() == 0) pending.delete(0);
            end else if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending.size() == 0) begin
                i_valid <= 1'b0;
            end else begin
                next_tok = pending.pop_front();
                i_valid         <= 1'b1;
                i_kind          <= next_tok.kind;
                i_operand_value <= next_tok.value;
                burst_left--;
                if (burst_left <= 0) new_burst();
            end
        end
    end

    // receiver stall pattern
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_hold = 0;
    int          run_left = 0;
    bit          run_stalled = 1'b0;

    always @(negedge i_clk) begin
        if (stall_hold > 0) begin
            stall_hold--;
        end else begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_hold = $urandom_range(20, 150);
        end
        case (stall_mode)
            STALL_NONE: begin
                i_stall <= 1'b0;
            end
            STALL_SCATTER: begin
                i_stall <= ($urandom_range(0, 2) == 0);
            end
            STALL_RUNS: begin
                if (run_left <= 0) begin
                    run_stalled = !run_stalled;
                    run_left = run_stalled ? $urandom_range(1, 12) : $urandom_range(1, 6);
                end
                run_left--;
                i_stall <= run_stalled;
            end
            default: begin
                i_stall <= cycle_count[0];
            end
        endcase
    end

    // monitor: check results first, then predict for the item taken at this edge
    t_postfix want;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (postfix_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result: kind %0d value %0d code %0d last %0b",
                                 o_out_kind, o_out_value, o_error_code, o_last);
                end else begin
                    want = postfix_q.pop_front();
                    if (o_out_kind !== want.kind || o_out_value !== want.value ||
                        o_error_code !== want.code || o_last !== want.last) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("mismatch: want %0d %0d %0d %0b, got %0d %0d %0d %0b",
                                     want.kind, want.value, want.code, want.last,
                                     o_out_kind, o_out_value, o_error_code, o_last);
                    end
                end
            end
            if (i_valid && !o_stall) shunt_token(i_kind, i_operand_value);
        end
        in_taken <= i_rst_n && i_valid && !o_stall;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        clear_shunt();
        build_directed();
        push_pause();
        build_random();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        while (pending.size() != 0 || i_valid || postfix_q.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        if (postfix_q.size() != 0) fail_count++;
        if (fail_count == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
